### hdl/tms_pkg.sv
package tms_pkg;

  localparam int CUSTOM_NOTES_DEF = 64;
  localparam int ROM_NOTES        = 48;
  localparam logic [3:0] WARNING_PATTERN = 4'd7;
  localparam logic [3:0] LAST_PATTERN    = 4'd9;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_START  = 3'd1,
    KIND_STOP   = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_CUSTOM = 3'd4
  } kind_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] dur;
  } note_t;

  function automatic note_t rom_note(input logic [5:0] idx);
    note_t n;
    case (idx)
      6'd0:  n = '{16'd988,  16'd100};
      6'd1:  n = '{16'd1319, 16'd300};
      6'd2:  n = '{16'd200,  16'd50};
      6'd3:  n = '{16'd150,  16'd50};
      6'd4:  n = '{16'd523,  16'd50};
      6'd5:  n = '{16'd659,  16'd50};
      6'd6:  n = '{16'd784,  16'd50};
      6'd7:  n = '{16'd1047, 16'd50};
      6'd8:  n = '{16'd1319, 16'd50};
      6'd9:  n = '{16'd1568, 16'd50};
      6'd10: n = '{16'd2093, 16'd150};
      6'd11: n = '{16'd1319, 16'd100};
      6'd12: n = '{16'd1568, 16'd100};
      6'd13: n = '{16'd2637, 16'd100};
      6'd14: n = '{16'd2093, 16'd100};
      6'd15: n = '{16'd2349, 16'd100};
      6'd16: n = '{16'd3136, 16'd200};
      6'd17: n = '{16'd659,  16'd150};
      6'd18: n = '{16'd0,    16'd50};
      6'd19: n = '{16'd784,  16'd150};
      6'd20: n = '{16'd0,    16'd50};
      6'd21: n = '{16'd880,  16'd150};
      6'd22: n = '{16'd0,    16'd50};
      6'd23: n = '{16'd784,  16'd150};
      6'd24: n = '{16'd0,    16'd50};
      6'd25: n = '{16'd659,  16'd300};
      6'd26: n = '{16'd0,    16'd100};
      6'd27: n = '{16'd523,  16'd150};
      6'd28: n = '{16'd0,    16'd50};
      6'd29: n = '{16'd587,  16'd150};
      6'd30: n = '{16'd0,    16'd50};
      6'd31: n = '{16'd659,  16'd400};
      6'd32: n = '{16'd2000, 16'd100};
      6'd33: n = '{16'd0,    16'd100};
      6'd34: n = '{16'd2000, 16'd100};
      6'd35: n = '{16'd0,    16'd100};
      6'd36: n = '{16'd2000, 16'd100};
      6'd37: n = '{16'd0,    16'd400};
      6'd38: n = '{16'd800,  16'd200};
      6'd39: n = '{16'd600,  16'd200};
      6'd40: n = '{16'd800,  16'd200};
      6'd41: n = '{16'd600,  16'd200};
      6'd42: n = '{16'd523,  16'd100};
      6'd43: n = '{16'd659,  16'd100};
      6'd44: n = '{16'd784,  16'd200};
      6'd45: n = '{16'd200,  16'd150};
      6'd46: n = '{16'd0,    16'd50};
      6'd47: n = '{16'd200,  16'd150};
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [5:0] pat_start(input logic [3:0] sel);
    logic [5:0] s;
    case (sel)
      4'd3:    s = 6'd2;
      4'd4:    s = 6'd4;
      4'd5:    s = 6'd11;
      4'd6:    s = 6'd17;
      4'd7:    s = 6'd32;
      4'd8:    s = 6'd38;
      4'd9:    s = 6'd42;
      4'd10:   s = 6'd45;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] pat_count(input logic [3:0] sel);
    logic [6:0] c;
    case (sel)
      4'd1:    c = 7'd2;
      4'd2:    c = 7'd2;
      4'd3:    c = 7'd7;
      4'd4:    c = 7'd6;
      4'd5:    c = 7'd15;
      4'd6:    c = 7'd6;
      4'd7:    c = 7'd4;
      4'd8:    c = 7'd3;
      4'd9:    c = 7'd3;
      default: c = 7'd0;
    endcase
    return c;
  endfunction

endpackage

### hdl/tms_ram.sv
module tms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/tone_melody_sequencer.sv
// Tone melody sequencer. Each accepted item (a 1 ms tick or a command) gives one result via
// a pending register, and a new item is taken every cycle while results keep being drained;
// an output register lets the next item enter while a result waits for out_ready. The custom
// note store is a RAM of CUSTOM_NOTES entries read once per cycle at the note now playing,
// with a write to that same entry forwarded; built-in patterns come from a constant table.
// The store has no reset and needs no clearing pass, so the block is ready right after reset.
module tone_melody_sequencer #(
  parameter int CUSTOM_NOTES = tms_pkg::CUSTOM_NOTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [3:0]  pattern_select,
  input  logic [5:0]  note_slot,
  input  logic [15:0] note_frequency,
  input  logic [15:0] note_duration,
  input  logic [6:0]  sequence_length,
  input  logic        loop_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] tone_frequency,
  output logic        tone_on,
  output logic [3:0]  active_pattern,
  output logic        sequence_active
);

  import tms_pkg::*;

  localparam int AddrW = (CUSTOM_NOTES > 1) ? $clog2(CUSTOM_NOTES) : 1;
  localparam logic [8:0] NumNotes = 9'(CUSTOM_NOTES);

  typedef enum logic [1:0] {
    TONE_KEEP,
    TONE_ZERO,
    TONE_NOTE
  } tone_op_t;

  logic [6:0]  pos, pos_next;
  logic [15:0] elapsed, elapsed_next;
  logic [3:0]  pattern, pattern_next;
  logic        from_custom, from_custom_next;
  logic [5:0]  table_base, table_base_next;
  logic [6:0]  seq_len, seq_len_next;
  logic        loop_mode, loop_mode_next;
  logic [15:0] tone_freq;

  logic        pend_valid;
  tone_op_t    pend_op;
  logic [3:0]  pend_pattern;
  logic        pend_active;
  logic        pend_move;
  tone_op_t    op;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  note_t            ram_rdata;
  logic             byp, byp_next;
  note_t            byp_data;

  logic [7:0]  rom_idx;
  note_t       rom_word;
  note_t       cur;
  logic [15:0] el_inc;
  logic [7:0]  nxt;
  logic [6:0]  len_clip;
  logic [15:0] tone_value;
  logic        accept;

  assign pend_move = pend_valid && (!out_valid || out_ready);
  assign in_ready  = !pend_valid || pend_move;
  assign accept    = in_valid && in_ready;

  assign rom_idx  = {2'b00, table_base} + {1'b0, pos};
  assign rom_word = (rom_idx < 8'(ROM_NOTES)) ? rom_note(rom_idx[5:0]) : '0;
  assign cur      = from_custom ? (byp ? byp_data : ram_rdata) : rom_word;

  assign el_inc   = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
  assign nxt      = {1'b0, pos} + 8'd1;
  assign len_clip = ({2'b00, sequence_length} > NumNotes) ? NumNotes[6:0] : sequence_length;

  always_comb begin
    pos_next         = pos;
    elapsed_next     = elapsed;
    pattern_next     = pattern;
    from_custom_next = from_custom;
    table_base_next  = table_base;
    seq_len_next     = seq_len;
    loop_mode_next   = loop_mode;
    op               = TONE_KEEP;
    wr_en            = 1'b0;
    if (accept) begin
      case (kind)
        KIND_TICK: begin
          if (seq_len != 7'd0) begin
            elapsed_next = el_inc;
            if (el_inc >= cur.dur) begin
              if (nxt >= {1'b0, seq_len} && !loop_mode) begin
                pattern_next     = 4'd0;
                seq_len_next     = 7'd0;
                from_custom_next = 1'b0;
                loop_mode_next   = 1'b0;
                op               = TONE_ZERO;
              end else begin
                pos_next     = (nxt >= {1'b0, seq_len}) ? 7'd0 : nxt[6:0];
                elapsed_next = 16'd0;
                op           = TONE_NOTE;
              end
            end
          end
        end
        KIND_START: begin
          from_custom_next = 1'b0;
          pattern_next     = 4'd0;
          seq_len_next     = 7'd0;
          loop_mode_next   = 1'b0;
          if (pattern_select >= 4'd1 && pattern_select <= LAST_PATTERN) begin
            pattern_next    = pattern_select;
            table_base_next = pat_start(pattern_select + 4'd1);
            seq_len_next    = pat_count(pattern_select);
            loop_mode_next  = (pattern_select == WARNING_PATTERN);
            op              = TONE_NOTE;
          end
          pos_next     = 7'd0;
          elapsed_next = 16'd0;
        end
        KIND_STOP: begin
          pattern_next     = 4'd0;
          seq_len_next     = 7'd0;
          from_custom_next = 1'b0;
          loop_mode_next   = 1'b0;
          op               = TONE_ZERO;
        end
        KIND_WRITE: begin
          wr_en = ({3'b000, note_slot} < NumNotes);
        end
        KIND_CUSTOM: begin
          pattern_next     = 4'd0;
          seq_len_next     = 7'd0;
          from_custom_next = 1'b0;
          loop_mode_next   = 1'b0;
          if (len_clip != 7'd0) begin
            from_custom_next = 1'b1;
            seq_len_next     = len_clip;
            loop_mode_next   = loop_flag;
            op               = TONE_NOTE;
          end
          pos_next     = 7'd0;
          elapsed_next = 16'd0;
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_addr  = AddrW'(note_slot);
  assign rd_addr  = ({2'b00, pos_next} < NumNotes) ? AddrW'(pos_next) : '0;
  assign byp_next = wr_en && (wr_addr == rd_addr);

  tms_ram #(
    .WIDTH ($bits(note_t)),
    .DEPTH (CUSTOM_NOTES)
  ) u_notes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({note_frequency, note_duration}),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    case (pend_op)
      TONE_NOTE: tone_value = cur.freq;
      TONE_ZERO: tone_value = 16'd0;
      default:   tone_value = tone_freq;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= 7'd0;
      elapsed     <= 16'd0;
      pattern     <= 4'd0;
      from_custom <= 1'b0;
      table_base  <= 6'd0;
      seq_len     <= 7'd0;
      loop_mode   <= 1'b0;
      tone_freq   <= 16'd0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      byp         <= 1'b0;
    end else begin
      pos         <= pos_next;
      elapsed     <= elapsed_next;
      pattern     <= pattern_next;
      from_custom <= from_custom_next;
      table_base  <= table_base_next;
      seq_len     <= seq_len_next;
      loop_mode   <= loop_mode_next;
      byp         <= byp_next;
      if (pend_move) begin
        tone_freq <= tone_value;
      end
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= {note_frequency, note_duration};
    if (accept) begin
      pend_op      <= op;
      pend_pattern <= pattern_next;
      pend_active  <= (seq_len_next != 7'd0);
    end
    if (pend_move) begin
      tone_frequency  <= tone_value;
      tone_on         <= (tone_value != 16'd0);
      active_pattern  <= pend_pattern;
      sequence_active <= pend_active;
    end
  end

endmodule

### hdl/tms_checker.sv
module tms_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] tone_frequency,
  input logic        tone_on,
  input logic [3:0]  active_pattern,
  input logic        sequence_active
);

  import tms_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tone_frequency) && $stable(active_pattern))
    else $error("Result changed or dropped while stalled.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tone_on == (tone_frequency != 16'd0)))
    else $error("Tone enable does not match the frequency.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (active_pattern != 4'd0) |-> sequence_active && active_pattern <= LAST_PATTERN)
    else $error("Built-in pattern shown without a running sequence.");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result offered right after reset.");

endmodule

bind tone_melody_sequencer tms_checker u_tms_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .tone_frequency  (tone_frequency),
  .tone_on         (tone_on),
  .active_pattern  (active_pattern),
  .sequence_active (sequence_active)
);
